>>> src/qte_pkg.sv
// Shared constants and the arctangent table for the quaternion to Euler block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int NUM_STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int SW = 35;           // product sums
  localparam int CW = 37;           // cordic x/y
  localparam int ZW = 28;           // Q24 angle
  localparam int SQ_STAGES = 32;    // isqrt, one result bit per stage
  localparam int CORDIC_LAT = NUM_STEPS + 1;
  localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    unique case (i)
      0: r = 28'sd13176795;  1: r = 28'sd7778716;  2: r = 28'sd4110060;
      3: r = 28'sd2086331;   4: r = 28'sd1047214;  5: r = 28'sd524117;
      6: r = 28'sd262123;    7: r = 28'sd131069;   8: r = 28'sd65536;
      9: r = 28'sd32768;    10: r = 28'sd16384;   11: r = 28'sd8192;
      12: r = 28'sd4096;    13: r = 28'sd2048;    14: r = 28'sd1024;
      15: r = 28'sd512;     16: r = 28'sd256;     17: r = 28'sd128;
      18: r = 28'sd64;      19: r = 28'sd32;      20: r = 28'sd16;
      21: r = 28'sd8;       22: r = 28'sd4;       23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> src/quaternion_to_euler_angles_top.sv
// Quaternion (Q1.15) to roll/pitch/yaw (Q3.13): products, sums, isqrt, three CORDICs.
// Depends on qte_pkg and qte_cordic.
// The pipeline depth is set by the 32-stage isqrt and the pitch CORDIC.
// Throughput: one word per cycle; the whole pipeline holds while the output word is not taken.
// Reset: rst (synchronous) clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [47:0] m_tdata,  // roll_angle, pitch_angle[14:0], yaw_angle, pad
  output logic       m_tuser    // pitch_saturated
);
  import qte_pkg::*;

  localparam int LAT = 3 + SQ_STAGES + CORDIC_LAT + 1;
  localparam int RY_DLY = 1 + SQ_STAGES;

  logic en;
  logic [LAT-1:0] vld;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[LAT-1];

  // stage 1: products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_wx, p_yz, p_wz, p_xy, p_wy, p_zx;
  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= qw * qw;  p_xx <= qx * qx;  p_yy <= qy * qy;  p_zz <= qz * qz;
      p_wx <= qw * qx;  p_yz <= qy * qz;  p_wz <= qw * qz;  p_xy <= qx * qy;
      p_wy <= qw * qy;  p_zx <= qz * qx;
    end
  end

  // stage 2: sums
  logic signed [SW-1:0] roll_y, roll_x, yaw_y, yaw_x, sp;
  always_ff @(posedge clk) begin
    if (en) begin
      roll_y <= (SW'(p_wx) + SW'(p_yz)) <<< 1;
      roll_x <= SW'(p_ww) - SW'(p_xx) - SW'(p_yy) + SW'(p_zz);
      yaw_y  <= (SW'(p_wz) + SW'(p_xy)) <<< 1;
      yaw_x  <= SW'(p_ww) + SW'(p_xx) - SW'(p_yy) - SW'(p_zz);
      sp     <= (SW'(p_wy) - SW'(p_zx)) <<< 1;
    end
  end

  logic sp_sat;
  assign sp_sat = (sp >= (SW'(1) <<< 30)) || (sp <= -(SW'(1) <<< 30));

  // stage 3: square of the sine term
  logic signed [30:0] sp_op;
  logic [61:0] sq;
  logic signed [SW-1:0] sp_d [0:SQ_STAGES];
  logic [SQ_STAGES:0] sat_d;
  assign sp_op = sp_sat ? '0 : sp[30:0];
  always_ff @(posedge clk) begin
    if (en) begin
      sq <= 62'(sp_op * sp_op);
      sp_d[0] <= sp;
      sat_d[0] <= sp_sat;
    end
  end

  // isqrt(2^60 - sq), one result bit per stage
  logic [63:0] rem [0:SQ_STAGES];
  logic [63:0] res [0:SQ_STAGES];
  assign rem[0] = (64'd1 << 60) - {2'b00, sq};
  assign res[0] = '0;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
        sp_d[k+1] <= sp_d[k];
        sat_d[k+1] <= sat_d[k];
      end
    end
  end

  logic signed [SW-1:0] cos_term;
  assign cos_term = SW'($signed({1'b0, res[SQ_STAGES][30:0]}));

  logic signed [ZW-1:0] z_roll, z_yaw, z_pitch;
  qte_cordic u_roll  (.clk(clk), .en(en), .y_in(roll_y), .x_in(roll_x), .z_out(z_roll));
  qte_cordic u_yaw   (.clk(clk), .en(en), .y_in(yaw_y), .x_in(yaw_x), .z_out(z_yaw));
  qte_cordic u_pitch (.clk(clk), .en(en), .y_in(sp_d[SQ_STAGES]), .x_in(cos_term),
                      .z_out(z_pitch));

  // align roll/yaw with pitch
  logic signed [ZW-1:0] roll_dl [0:RY_DLY-1];
  logic signed [ZW-1:0] yaw_dl  [0:RY_DLY-1];
  logic [1:0] tag_dl [0:CORDIC_LAT-1];   // {sat, positive}
  always_ff @(posedge clk) begin
    if (en) begin
      roll_dl[0] <= z_roll;
      yaw_dl[0] <= z_yaw;
      for (int j = 1; j < RY_DLY; j++) begin
        roll_dl[j] <= roll_dl[j-1];
        yaw_dl[j] <= yaw_dl[j-1];
      end
      tag_dl[0] <= {sat_d[SQ_STAGES], (sp_d[SQ_STAGES] > 0)};
      for (int j = 1; j < CORDIC_LAT; j++) begin
        tag_dl[j] <= tag_dl[j-1];
      end
    end
  end

  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a,
                                               input logic signed [15:0] lim);
    logic signed [ZW:0] q;
    q = (ZW'(a) + (ZW+1)'(1024)) >>> 11;
    if (q > (ZW+1)'(lim)) q = (ZW+1)'(lim);
    if (q < -((ZW+1)'(lim))) q = -((ZW+1)'(lim));
    return q[15:0];
  endfunction

  logic signed [15:0] roll_q, yaw_q, pitch_q;
  logic [1:0] tag;
  assign tag = tag_dl[CORDIC_LAT-1];
  always_comb begin
    roll_q = to_q13(roll_dl[RY_DLY-1], PI_Q13);
    yaw_q = to_q13(yaw_dl[RY_DLY-1], PI_Q13);
    if (tag[1]) begin
      pitch_q = tag[0] ? HALF_PI_Q13 : -HALF_PI_Q13;
    end else begin
      pitch_q = to_q13(z_pitch, HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, yaw_q, pitch_q[14:0], roll_q};
      m_tuser <= tag[1];
    end
  end

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow output stall");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[30:16] == 15'sd12868 || m_tdata[30:16] == -15'sd12868))
    else $error("saturated pitch not at +-pi/2");
  a_roll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736 && $signed(m_tdata[15:0]) >= -16'sd25736))
    else $error("roll out of range");
endmodule
`default_nettype wire

>>> src/qte_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q24 radians.
// Depends on qte_pkg. Advances on en.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic (
  input  wire                                 clk,
  input  wire                                 en,
  input  wire logic signed [qte_pkg::SW-1:0]  y_in,
  input  wire logic signed [qte_pkg::SW-1:0]  x_in,
  output logic signed [qte_pkg::ZW-1:0]       z_out
);
  import qte_pkg::*;

  logic signed [CW-1:0] xs [0:NUM_STEPS];
  logic signed [CW-1:0] ys [0:NUM_STEPS];
  logic signed [ZW-1:0] zs [0:NUM_STEPS];

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        xs[0] <= -CW'(x_in);
        ys[0] <= -CW'(y_in);
        zs[0] <= (y_in >= 0) ? PI_Q24 : -PI_Q24;
      end else begin
        xs[0] <= CW'(x_in);
        ys[0] <= CW'(y_in);
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    logic signed [CW-1:0] x_next, y_next;
    logic signed [ZW-1:0] z_next;
    always_comb begin
      x_next = xs[i];
      y_next = ys[i];
      z_next = zs[i];
      if (ys[i] > 0) begin
        x_next = xs[i] + (ys[i] >>> i);
        y_next = ys[i] - (xs[i] >>> i);
        z_next = zs[i] + atan_q24(i);
      end else if (ys[i] < 0) begin
        x_next = xs[i] - (ys[i] >>> i);
        y_next = ys[i] + (xs[i] >>> i);
        z_next = zs[i] - atan_q24(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1] <= x_next;
        ys[i+1] <= y_next;
        zs[i+1] <= z_next;
      end
    end
  end

  assign z_out = zs[NUM_STEPS];
endmodule
`default_nettype wire
